[src/slc_pkg.sv]
package slc_pkg;

    localparam int SETS_DEF      = 64;
    localparam int WAYS_DEF      = 8;
    localparam int ADDR_BITS_DEF = 64;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX    = 8'd1;

    localparam logic [3:0] BLOCK_OFFSET_RST = 4'd6;
    localparam logic [2:0] SET_INDEX_RST    = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_UPDATE
    } back_state_t;

endpackage

[src/slc_ram.sv]
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/slc_front.sv]
module slc_front #(
    parameter int SETS      = slc_pkg::SETS_DEF,
    parameter int ADDR_BITS = slc_pkg::ADDR_BITS_DEF,
    parameter int SW        = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [63:0]          addr,
    input  logic [3:0]           block_offset_bits,
    input  logic [2:0]           set_index_bits,
    input  logic                 q_pop,
    output logic                 q_empty,
    output logic [SW-1:0]        q_set,
    output logic [ADDR_BITS-1:0] q_tag
);

    localparam int LIM   = $clog2(SETS + 1) - 1;
    localparam int DEPTH = slc_pkg::QUEUE_DEPTH;
    localparam int ENT_W = SW + ADDR_BITS;

    logic [ADDR_BITS-1:0] a;
    logic [2:0]           sbits;
    logic [ADDR_BITS-1:0] shifted;
    logic [ADDR_BITS-1:0] set_mask;
    logic [ADDR_BITS-1:0] set_full;
    logic [SW-1:0]        set_val;
    logic [4:0]           shift;
    logic [ADDR_BITS-1:0] tag_val;

    logic [ENT_W-1:0] ent_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push;

    // split the address into set and tag
    always_comb
    begin
        a        = addr[ADDR_BITS-1:0];
        sbits    = (int'(set_index_bits) > LIM) ? 3'(LIM) : set_index_bits;
        shifted  = a >> block_offset_bits;
        set_mask = (ADDR_BITS'(1) << sbits) - ADDR_BITS'(1);
        set_full = shifted & set_mask;
        set_val  = (set_full >= ADDR_BITS'(SETS)) ? '0 : set_full[SW-1:0];
        shift    = {1'b0, block_offset_bits} + {2'b00, sbits};
        tag_val  = (int'(shift) >= ADDR_BITS) ? '0 : (a >> shift);
    end

    assign full    = (cnt_reg == 2'(DEPTH));
    assign q_empty = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign {q_set, q_tag} = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= {set_val, tag_val};
        end
    end

endmodule

[src/slc_back.sv]
module slc_back #(
    parameter int SETS      = slc_pkg::SETS_DEF,
    parameter int WAYS      = slc_pkg::WAYS_DEF,
    parameter int ADDR_BITS = slc_pkg::ADDR_BITS_DEF,
    parameter int SW        = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [SW-1:0]        q_set,
    input  logic [ADDR_BITS-1:0] q_tag,
    output logic                 q_pop,
    input  logic                 res_room,
    output logic                 res_push,
    output logic                 res_hit,
    output logic [2:0]           res_way,
    output logic [31:0]          res_hit_count,
    output logic [31:0]          res_miss_count
);

    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W = WAYS * ADDR_BITS;
    localparam int LRU_W = WAYS * WW;
    localparam int LV_W  = LRU_W + WAYS;

    slc_pkg::back_state_t state_reg, state_next;

    logic [SW-1:0]        set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [SETS-1:0]      lru_init_reg;
    logic [31:0]          hits_reg, hits_next;
    logic [31:0]          misses_reg, misses_next;

    logic [TAG_W-1:0] tag_rd, tag_wr;
    logic [LV_W-1:0]  lru_rd, lru_wr;
    logic             in_update;

    logic [WW-1:0] order     [WAYS];
    logic [WW-1:0] new_order [WAYS];
    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] valid_cur, valid_new;
    logic [WW-1:0] hit_way, victim, sel_way;
    logic          hit;
    logic          seen;

    slc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag_ram (
        .clk   (clk),
        .we    (in_update && !hit),
        .waddr (set_reg),
        .wdata (tag_wr),
        .raddr (set_reg),
        .rdata (tag_rd)
    );

    // LRU order and valid bits of a set share one word
    slc_ram #(.WIDTH(LV_W), .DEPTH(SETS)) u_lru_ram (
        .clk   (clk),
        .we    (in_update),
        .waddr (set_reg),
        .wdata (lru_wr),
        .raddr (set_reg),
        .rdata (lru_rd)
    );

    // tag compare, victim pick and LRU reorder
    always_comb
    begin
        valid_cur = lru_init_reg[set_reg] ? lru_rd[LRU_W +: WAYS] : '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = valid_cur[w] &&
                         (tag_rd[w*ADDR_BITS +: ADDR_BITS] == tag_reg);
            order[w]   = lru_init_reg[set_reg] ? lru_rd[w*WW +: WW] : WW'(w);
        end
        hit     = |hit_vec;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WW'(w);
            end
        end
        victim  = (int'(order[0]) >= WAYS) ? '0 : order[0];
        sel_way = hit ? hit_way : victim;
        seen    = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            seen = seen || (order[i] == sel_way);
            if (!seen)
            begin
                new_order[i] = order[i];
            end
            else if (i < WAYS - 1)
            begin
                new_order[i] = order[(i + 1) % WAYS];
            end
            else
            begin
                new_order[i] = sel_way;
            end
        end
        valid_new = valid_cur;
        if (!hit)
        begin
            valid_new[victim] = 1'b1;
        end
        for (int i = 0; i < WAYS; i++)
        begin
            lru_wr[i*WW +: WW] = new_order[i];
        end
        lru_wr[LRU_W +: WAYS] = valid_new;
        tag_wr = tag_rd;
        tag_wr[victim*ADDR_BITS +: ADDR_BITS] = tag_reg;
        hits_next   = hits_reg + 32'(hit);
        misses_next = misses_reg + 32'(!hit);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slc_pkg::BK_IDLE:
            begin
                if (!q_empty && res_room)
                begin
                    state_next = slc_pkg::BK_READ;
                end
            end
            slc_pkg::BK_READ:   state_next = slc_pkg::BK_UPDATE;
            slc_pkg::BK_UPDATE: state_next = slc_pkg::BK_IDLE;
            default:            state_next = slc_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        in_update = 1'b0;
        unique case (state_reg)
            slc_pkg::BK_IDLE:   q_pop = !q_empty && res_room;
            slc_pkg::BK_READ:   q_pop = 1'b0;
            slc_pkg::BK_UPDATE: in_update = 1'b1;
            default:            q_pop = 1'b0;
        endcase
    end

    assign res_push       = in_update;
    assign res_hit        = hit;
    assign res_way        = 3'(sel_way);
    assign res_hit_count  = hits_next;
    assign res_miss_count = misses_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= slc_pkg::BK_IDLE;
            lru_init_reg <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_update)
            begin
                lru_init_reg[set_reg] <= 1'b1;
                hits_reg              <= hits_next;
                misses_reg            <= misses_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
        end
    end

endmodule

[src/set_assoc_lru_cache_lookup.sv]
// Set-associative cache lookup with true LRU replacement.
//
// Input channel: drive addr and push; the address is taken at a rising edge
// with push high and full low. The front splits it into set and tag by the
// block_offset_bits and set_index_bits registers and holds it in a two-entry
// queue.
// Result channel: while empty is low, hit, way, hit_count and miss_count show
// the oldest result; raise pop to take it. A stalled receiver fills the
// two-entry result queue; the back engine then waits and the input queue
// backs up until full rises.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 = block_offset_bits,
// 1 = set_index_bits) and cfg_data; cfg_ready is always high. Write only
// while the block is idle.
// After accept, an item passes the input queue, then the back engine (idle,
// tag/LRU RAM read, compare and write back) and the result queue. The back
// engine handles one item at a time, and starts one only with a free result slot.
// Reset: all valid bits clear, every set's LRU order returns to 0..WAYS-1,
// counters clear and registers go to 6/6. A per-set written flag stands in
// for the cleared valid bits and LRU order, so no clearing pass is needed.
module set_assoc_lru_cache_lookup #(
    parameter int SETS      = slc_pkg::SETS_DEF,
    parameter int WAYS      = slc_pkg::WAYS_DEF,
    parameter int ADDR_BITS = slc_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [63:0]                    addr,
    output logic                           empty,
    input  logic                           pop,
    output logic                           hit,
    output logic [2:0]                     way,
    output logic [31:0]                    hit_count,
    output logic [31:0]                    miss_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RES_W = 1 + 3 + 32 + 32;
    localparam int DEPTH = slc_pkg::QUEUE_DEPTH;

    logic [3:0] block_offset_reg;
    logic [2:0] set_index_reg;

    logic                 q_pop, q_empty;
    logic [SW-1:0]        q_set;
    logic [ADDR_BITS-1:0] q_tag;

    logic        res_room, res_push, res_hit;
    logic [2:0]  res_way;
    logic [31:0] res_hit_count, res_miss_count;

    logic [RES_W-1:0] res_reg [DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_offset_reg <= slc_pkg::BLOCK_OFFSET_RST;
            set_index_reg    <= slc_pkg::SET_INDEX_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == slc_pkg::CFG_BLOCK_OFFSET)
            begin
                block_offset_reg <= cfg_data[3:0];
            end
            else if (cfg_index == slc_pkg::CFG_SET_INDEX)
            begin
                set_index_reg <= cfg_data[2:0];
            end
        end
    end

    slc_front #(.SETS(SETS), .ADDR_BITS(ADDR_BITS), .SW(SW)) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .addr              (addr),
        .block_offset_bits (block_offset_reg),
        .set_index_bits    (set_index_reg),
        .q_pop             (q_pop),
        .q_empty           (q_empty),
        .q_set             (q_set),
        .q_tag             (q_tag)
    );

    slc_back #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS), .SW(SW)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_set          (q_set),
        .q_tag          (q_tag),
        .q_pop          (q_pop),
        .res_room       (res_room),
        .res_push       (res_push),
        .res_hit        (res_hit),
        .res_way        (res_way),
        .res_hit_count  (res_hit_count),
        .res_miss_count (res_miss_count)
    );

    // result queue: the back engine starts an item only with a free slot here
    assign res_room = (cnt_reg != 2'(DEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign {hit, way, hit_count, miss_count} = res_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(res_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg[wr_ptr_reg] <= {res_hit, res_way, res_hit_count, res_miss_count};
        end
    end

    // never push a result into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (cnt_reg != 2'(DEPTH)))
        else $error("result queue overflow");

    // the back engine takes an item only when the front holds one
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty input queue");

    // one item in flight: results never come on consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !res_push)
        else $error("back engine overlapped two items");

endmodule

[tb/tb_set_assoc_lru_cache_lookup.sv]
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_lookup;

    localparam int SETS      = slc_pkg::SETS_DEF;
    localparam int WAYS      = slc_pkg::WAYS_DEF;
    localparam int ADDR_BITS = slc_pkg::ADDR_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    // Ports
    logic                           clk;
    logic                           rst_n;
    logic                           push;
    logic                           full;
    logic [63:0]                    addr;
    logic                           empty;
    logic                           pop;
    logic                           hit;
    logic [2:0]                     way;
    logic [31:0]                    hit_count;
    logic [31:0]                    miss_count;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [slc_pkg::CFG_DATA_W-1:0] cfg_data;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } lookup_t;

    // Predictor state: our own copy of the cache directory
    logic [63:0] tags_m   [SETS*WAYS];
    logic        valids_m [SETS*WAYS];
    int          order_m  [SETS][WAYS];
    logic [31:0] hits_m;
    logic [31:0] misses_m;
    logic [3:0]  offset_bits_m;
    logic [2:0]  index_bits_m;

    lookup_t     lookups_due[$];
    int          errors;
    int          cycles;
    bit          rx_hold;   // forces the receiver off for a long stretch
    int          hold_cycles;

    set_assoc_lru_cache_lookup #(
        .SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)
    ) uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .addr(addr),
        .empty(empty), .pop(pop), .hit(hit), .way(way), .hit_count(hit_count),
        .miss_count(miss_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear the predictor to the reset state of the block
    task automatic reset_directory();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                valids_m[s*WAYS+w] = 1'b0;
                tags_m[s*WAYS+w]   = '0;
                order_m[s][w]      = w;
            end
        end
        hits_m        = '0;
        misses_m      = '0;
        offset_bits_m = slc_pkg::BLOCK_OFFSET_RST;
        index_bits_m  = slc_pkg::SET_INDEX_RST;
    endtask

    // Look one address up in the predicted directory and update it
    function automatic lookup_t predict_lookup(logic [63:0] a);
        lookup_t r;
        int sbits, lim, shift, set, w_sel, pos;
        logic [63:0] tag;
        logic found;
        lim = $clog2(SETS);
        if ((1 << lim) > SETS)
            lim--;
        sbits = (index_bits_m > lim) ? lim : index_bits_m;
        set   = int'((a >> offset_bits_m) & ((64'd1 << sbits) - 64'd1));
        if (set >= SETS)
            set = 0;
        shift = offset_bits_m + sbits;
        tag   = (shift >= ADDR_BITS || shift >= 64) ? 64'd0 : (a >> shift);
        found = 1'b0;
        w_sel = 0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && valids_m[set*WAYS+w] && tags_m[set*WAYS+w] == tag)
            begin
                found = 1'b1;
                w_sel = w;
            end
        end
        if (found)
            hits_m++;
        else
        begin
            w_sel = order_m[set][0];
            tags_m[set*WAYS+w_sel]   = tag;
            valids_m[set*WAYS+w_sel] = 1'b1;
            misses_m++;
        end
        // move the way to the most recent end
        pos = 0;
        while (pos < WAYS && order_m[set][pos] != w_sel)
            pos++;
        for (int i = pos; i + 1 < WAYS; i++)
            order_m[set][i] = order_m[set][i+1];
        order_m[set][WAYS-1] = w_sel;
        r.hit        = found;
        r.way        = w_sel[2:0];
        r.hit_count  = hits_m;
        r.miss_count = misses_m;
        return r;
    endfunction

    // Send one address; hold push until the block takes it
    task automatic send_addr(logic [63:0] a);
        push <= 1'b1;
        addr <= a;
        @(posedge clk);
        while (full)
            @(posedge clk);
        lookups_due.push_back(predict_lookup(a));
    endtask

    // Drop push, then idle for a random gap; no gap keeps push high
    task automatic idle_gap(int max_gap);
        int n;
        n = $urandom_range(0, max_gap);
        if (n > 0)
        begin
            push <= 1'b0;
            for (int i = 0; i < n; i++)
                @(posedge clk);
        end
    endtask

    // Wait until every predicted lookup has come back, plus the pipeline tail
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(logic [slc_pkg::CFG_IDX_W-1:0] idx,
                             logic [slc_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == slc_pkg::CFG_BLOCK_OFFSET)
            offset_bits_m = val[3:0];
        else if (idx == slc_pkg::CFG_SET_INDEX)
            index_bits_m = val[2:0];
    endtask

    // Random address: mostly a small pool of tags per set, for reuse and eviction
    function automatic logic [63:0] pick_addr();
        logic [63:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: a = '0;
            1: a = '1;
            2, 3: a = a;
            default: a = {40'd0, 8'($urandom_range(0, 11)), a[15:0]} &
                         {40'd0, 8'hff, 16'hffff};
        endcase
        if ($urandom_range(0, 3) == 0)
            a[63:20] = {$urandom, 12'($urandom)};
        return a;
    endfunction

    task automatic run_random(int count, int burst_max, int gap_max);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, burst_max);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_addr(pick_addr());
                sent++;
            end
            idle_gap(gap_max);
        end
    endtask

    // Directed: extremes of the address, hits, LRU eviction order, wide splits
    task automatic test_directed();
        send_addr(64'd0);
        send_addr(64'd0);
        send_addr('1);
        send_addr(64'h8000_0000_0000_0000);
        // nine distinct tags into set 0: fills all ways, then evicts the oldest
        for (int t = 1; t <= 9; t++)
            send_addr(64'(t) << 12);
        send_addr(64'd1 << 12);
        send_addr(64'd9 << 12);
        idle_gap(3);
        // too many set bits saturates; an offset of 0xff is cut to 15, the largest offset
        write_reg(slc_pkg::CFG_SET_INDEX, 8'hff);
        send_addr(64'h0000_0000_0000_0fc0);
        write_reg(slc_pkg::CFG_BLOCK_OFFSET, 8'hff);
        send_addr(64'h1234_5678_9abc_def0);
        send_addr('1);
        write_reg(slc_pkg::CFG_BLOCK_OFFSET, 8'd0);
        write_reg(slc_pkg::CFG_SET_INDEX, 8'd0);
        send_addr(64'h5555_5555_5555_5555);
        send_addr(64'haaaa_aaaa_aaaa_aaaa);
        send_addr(64'h5555_5555_5555_5555);
        drain();
    endtask

    // Fill the block while the receiver holds off, then pause for a full drain
    task automatic test_backpressure();
        hold_cycles = 60;
        rx_hold = 1'b1;
        for (int i = 0; i < 12; i++)
            send_addr(pick_addr());
        drain();
    endtask

    // Random phases across several register settings, extremes included
    task automatic test_random_settings();
        logic [3:0] offs [5] = '{4'd6, 4'd0, 4'd12, 4'd15, 4'd3};
        logic [2:0] idxs [5] = '{3'd6, 3'd0, 3'd7, 3'd2, 3'd4};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(slc_pkg::CFG_BLOCK_OFFSET, {4'd0, offs[p]});
            write_reg(slc_pkg::CFG_SET_INDEX, {5'd0, idxs[p]});
            run_random(320, 12, 5);
        end
        drain();
    endtask

    // Receiver: pop on a pattern of its own, check against the oldest lookup
    always @(posedge clk)
    begin
        lookup_t exp_r;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (lookups_due.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b way=%0d", $time, hit, way);
                    errors++;
                end
                else
                begin
                    exp_r = lookups_due.pop_front();
                    if (hit !== exp_r.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit);
                        errors++;
                    end
                    if (way !== exp_r.way)
                    begin
                        $display("%0t: way expected %0d actual %0d", $time, exp_r.way, way);
                        errors++;
                    end
                    if (hit_count !== exp_r.hit_count)
                    begin
                        $display("%0t: hit_count expected %0d actual %0d", $time,
                                 exp_r.hit_count, hit_count);
                        errors++;
                    end
                    if (miss_count !== exp_r.miss_count)
                    begin
                        $display("%0t: miss_count expected %0d actual %0d", $time,
                                 exp_r.miss_count, miss_count);
                        errors++;
                    end
                end
            end
            // long hold-off counted here; otherwise stall in random runs
            if (rx_hold)
            begin
                pop <= 1'b0;
                hold_cycles--;
                if (hold_cycles <= 0)
                    rx_hold = 1'b0;
            end
            else if ((cycles / 200) % 3 == 0)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        addr      = '0;
        pop       = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        rx_hold   = 1'b0;
        hold_cycles = 0;
        reset_directory();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_settings();

        if (errors == 0 && lookups_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
src/slc_pkg.sv
src/slc_ram.sv
src/slc_front.sv
src/slc_back.sv
src/set_assoc_lru_cache_lookup.sv
tb/tb_set_assoc_lru_cache_lookup.sv
